### rtl/core/nmea_fx_pkg.sv
// Shared types and constants for the NMEA GGA/RMC field extractor.
`timescale 1ns / 1ps
`default_nettype none
package nmea_fx_pkg;

  localparam logic [1:0] TYPE_OTHER = 2'd0;
  localparam logic [1:0] TYPE_GGA   = 2'd1;
  localparam logic [1:0] TYPE_RMC   = 2'd2;

  localparam logic [3:0] FID_TIME    = 4'd0;
  localparam logic [3:0] FID_LAT     = 4'd1;
  localparam logic [3:0] FID_LATDIR  = 4'd2;
  localparam logic [3:0] FID_LON     = 4'd3;
  localparam logic [3:0] FID_LONDIR  = 4'd4;
  localparam logic [3:0] FID_FIELD11 = 4'd5;
  localparam logic [3:0] FID_SPEED   = 4'd6;
  localparam logic [3:0] FID_COURSE  = 4'd7;
  localparam logic [3:0] FID_DATE    = 4'd8;
  localparam logic [3:0] FID_NONE    = 4'd15;

  localparam logic [1:0] REG_GGA_MIN   = 2'd0;
  localparam logic [1:0] REG_RMC_MIN   = 2'd1;
  localparam logic [1:0] REG_FIELD_MAX = 2'd2;

  localparam logic [39:0] GGA_NAME = 40'h4750474741;
  localparam logic [39:0] RMC_NAME = 40'h4750524D43;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;

  typedef struct packed {
    logic       pair_ready;
    logic       accepted;
    logic [1:0] sentence_type;
    logic [7:0] char_value;
    logic [3:0] field_id;
    logic       kind;
  } result_t;

endpackage
`default_nettype wire

### rtl/core/nmea_gga_rmc_field_extractor.sv
// Top level of the NMEA GGA/RMC field extractor: byte parser and result stage.
// Each result is registered in the result register, or in the skid if it stalls.
// Throughput: one byte per cycle while s_tready is high; each byte updates the
// sentence counters and type compare in one pass from input to result register.
// A two-entry output stage (result register plus skid) keeps s_tready high
// while one result waits. Synchronous reset clears all sentence state and the
// pair flags and loads the register defaults (GGA 15, RMC 10, field chars 15).
`timescale 1ns / 1ps
`default_nettype none
module nmea_gga_rmc_field_extractor #(
  parameter int MAX_SENTENCE_BYTES = 255,
  parameter int MAX_TOKENS         = 20,
  parameter int FIELD_CHARS        = 15
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
  input  wire logic        s_tlast,   // end_of_input
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [3:0] field_id, [11:4] char_value,
                                      // [13:12] sentence_type, [14] accepted,
                                      // [15] pair_ready
  output logic             m_tuser,   // kind
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);
  import nmea_fx_pkg::*;

  localparam logic [7:0] MaxBytes  = 8'(MAX_SENTENCE_BYTES);
  localparam logic [4:0] LastToken = 5'(MAX_TOKENS - 1);
  localparam logic [3:0] FieldCap  = 4'(FIELD_CHARS);

  logic [4:0]  gga_min;
  logic [4:0]  rmc_min;
  logic [3:0]  field_max;

  logic        in_sentence, in_sentence_next;
  logic [7:0]  sentence_bytes, sentence_bytes_next;
  logic [4:0]  token_index, token_index_next;
  logic [3:0]  token_chars, token_chars_next;
  logic [39:0] type_text, type_text_next;
  logic [2:0]  type_length, type_length_next;
  logic [1:0]  current_type, current_type_next;
  logic        gga_seen, gga_seen_next;
  logic        rmc_seen, rmc_seen_next;

  logic        accept;
  logic        push;
  result_t     res;
  logic [1:0]  classified;
  logic [1:0]  done_type;
  logic [5:0]  tok_total;
  logic        acc_gga, acc_rmc;
  logic        seen_g, seen_r;
  logic [3:0]  multi_limit;
  logic [3:0]  limit;
  logic [3:0]  fid;

  result_t     out_reg;
  result_t     skid;
  logic        skid_valid;
  logic        out_free;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !skid_valid;

  always_comb begin
    if (type_length != 3'd5) begin
      classified = TYPE_OTHER;
    end else if (type_text == GGA_NAME) begin
      classified = TYPE_GGA;
    end else if (type_text == RMC_NAME) begin
      classified = TYPE_RMC;
    end else begin
      classified = TYPE_OTHER;
    end
  end

  assign multi_limit = (field_max < FieldCap) ? field_max : FieldCap;

  always_comb begin
    fid   = FID_NONE;
    limit = multi_limit;
    if (current_type == TYPE_GGA) begin
      case (token_index)
        5'd1:  fid = FID_TIME;
        5'd2:  fid = FID_LAT;
        5'd3: begin
          fid   = FID_LATDIR;
          limit = 4'd1;
        end
        5'd4:  fid = FID_LON;
        5'd5: begin
          fid   = FID_LONDIR;
          limit = 4'd1;
        end
        5'd11: fid = FID_FIELD11;
        default: fid = FID_NONE;
      endcase
    end else if (current_type == TYPE_RMC) begin
      case (token_index)
        5'd7:  fid = FID_SPEED;
        5'd8:  fid = FID_COURSE;
        5'd9:  fid = FID_DATE;
        default: fid = FID_NONE;
      endcase
    end
  end

  assign done_type = (token_index == 5'd0) ? classified : current_type;
  assign tok_total = {1'b0, token_index} + 6'd1;
  assign acc_gga   = (done_type == TYPE_GGA) && (tok_total >= {1'b0, gga_min});
  assign acc_rmc   = (done_type == TYPE_RMC) && (tok_total >= {1'b0, rmc_min});
  assign seen_g    = gga_seen || acc_gga;
  assign seen_r    = rmc_seen || acc_rmc;

  always_comb begin
    in_sentence_next    = in_sentence;
    sentence_bytes_next = sentence_bytes;
    token_index_next    = token_index;
    token_chars_next    = token_chars;
    type_text_next      = type_text;
    type_length_next    = type_length;
    current_type_next   = current_type;
    gga_seen_next       = gga_seen;
    rmc_seen_next       = rmc_seen;
    push                = 1'b0;
    res                 = '0;
    if (accept) begin
      if (s_tlast || s_tdata == CHAR_DOLLAR) begin
        if (in_sentence && sentence_bytes != 8'd0) begin
          push              = 1'b1;
          res.kind          = 1'b1;
          res.sentence_type = done_type;
          res.accepted      = acc_gga || acc_rmc;
          res.pair_ready    = seen_g && seen_r;
          gga_seen_next     = seen_g && !(seen_g && seen_r);
          rmc_seen_next     = seen_r && !(seen_g && seen_r);
        end
        in_sentence_next    = !s_tlast;
        sentence_bytes_next = 8'd0;
        token_index_next    = 5'd0;
        token_chars_next    = 4'd0;
        type_text_next      = '0;
        type_length_next    = 3'd0;
        current_type_next   = TYPE_OTHER;
      end else if (in_sentence && sentence_bytes < MaxBytes) begin
        sentence_bytes_next = sentence_bytes + 8'd1;
        if (s_tdata == CHAR_COMMA && token_index < LastToken) begin
          if (token_index == 5'd0) begin
            current_type_next = classified;
          end
          token_index_next = token_index + 5'd1;
          token_chars_next = 4'd0;
        end else if (token_index == 5'd0) begin
          if (type_length < 3'd5) begin
            type_text_next = {type_text[31:0], s_tdata};
          end
          if (type_length < 3'd6) begin
            type_length_next = type_length + 3'd1;
          end
        end else if (fid != FID_NONE && token_chars < limit) begin
          token_chars_next  = token_chars + 4'd1;
          push              = 1'b1;
          res.kind          = 1'b0;
          res.field_id      = fid;
          res.char_value    = s_tdata;
          res.sentence_type = current_type;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gga_min   <= 5'd15;
      rmc_min   <= 5'd10;
      field_max <= 4'd15;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GGA_MIN:   gga_min   <= cfg_data;
        REG_RMC_MIN:   rmc_min   <= cfg_data;
        REG_FIELD_MAX: field_max <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence    <= 1'b0;
      sentence_bytes <= 8'd0;
      token_index    <= 5'd0;
      token_chars    <= 4'd0;
      type_text      <= '0;
      type_length    <= 3'd0;
      current_type   <= TYPE_OTHER;
      gga_seen       <= 1'b0;
      rmc_seen       <= 1'b0;
    end else begin
      in_sentence    <= in_sentence_next;
      sentence_bytes <= sentence_bytes_next;
      token_index    <= token_index_next;
      token_chars    <= token_chars_next;
      type_text      <= type_text_next;
      type_length    <= type_length_next;
      current_type   <= current_type_next;
      gga_seen       <= gga_seen_next;
      rmc_seen       <= rmc_seen_next;
    end
  end

  // Result register with one skid entry behind it.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_reg <= skid;
      end else if (push) begin
        out_reg <= res;
      end
    end else if (push) begin
      skid <= res;
    end
  end

  assign m_tuser = out_reg.kind;
  assign m_tdata = {out_reg.pair_ready, out_reg.accepted, out_reg.sentence_type,
                    out_reg.char_value, out_reg.field_id};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry held while result register empty");

  a_char_has_type: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |->
      (out_reg.sentence_type == TYPE_GGA || out_reg.sentence_type == TYPE_RMC))
    else $error("field character from a sentence of no known type");

  a_accept_on_report: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_reg.accepted) |->
      (m_tuser && out_reg.sentence_type != TYPE_OTHER))
    else $error("accepted flag outside a typed report");

  a_pair_clears: assert property (@(posedge clk) disable iff (rst)
    !(gga_seen && rmc_seen))
    else $error("pair flags both held after a report");

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking stream testbench for the NMEA GGA/RMC field extractor.
`timescale 1ns / 1ps
module tb_top;
  import nmea_fx_pkg::*;

  localparam int SENTENCE_LIMIT = 255;
  localparam int TOKEN_LIMIT    = 20;
  localparam int FIELD_LIMIT    = 15;
  localparam int RANDOM_BYTES   = 450;
  localparam int PHASE_BYTES    = 20;
  localparam int PHASE_COUNT    = 5;
  localparam int DRAIN_CYCLES   = 4;
  localparam int RUN_LIMIT_NS   = 2_000_000;

  class nmea_field_scoreboard;
    int          gga_min;
    int          rmc_min;
    int          field_max;
    bit          in_sentence;
    int          sentence_bytes;
    int          token_index;
    int          token_chars;
    int          type_length;
    logic [39:0] type_text;
    logic [1:0]  current_type;
    bit          gga_seen;
    bit          rmc_seen;
    result_t     expected_fields[$];
    int          errors;

    function new();
      gga_min = 15;
      rmc_min = 10;
      field_max = 15;
      in_sentence = 0;
      gga_seen = 0;
      rmc_seen = 0;
      errors = 0;
      clear_sentence();
    endfunction

    function void clear_sentence();
      sentence_bytes = 0;
      token_index = 0;
      token_chars = 0;
      type_text = '0;
      type_length = 0;
      current_type = TYPE_OTHER;
    endfunction

    function int pending();
      return expected_fields.size();
    endfunction

    function void write_reg(logic [1:0] idx, logic [4:0] value);
      case (idx)
        REG_GGA_MIN:   gga_min = value;
        REG_RMC_MIN:   rmc_min = value;
        REG_FIELD_MAX: field_max = value[3:0];
        default: ;
      endcase
    endfunction

    function logic [1:0] name_type();
      if (type_length != 5) return TYPE_OTHER;
      if (type_text == GGA_NAME) return TYPE_GGA;
      if (type_text == RMC_NAME) return TYPE_RMC;
      return TYPE_OTHER;
    endfunction

    function logic [3:0] token_field(output int limit);
      limit = (field_max < FIELD_LIMIT) ? field_max : FIELD_LIMIT;
      if (current_type == TYPE_GGA) begin
        case (token_index)
          1: return FID_TIME;
          2: return FID_LAT;
          3: begin
            limit = 1;
            return FID_LATDIR;
          end
          4: return FID_LON;
          5: begin
            limit = 1;
            return FID_LONDIR;
          end
          11: return FID_FIELD11;
          default: return FID_NONE;
        endcase
      end
      if (current_type == TYPE_RMC) begin
        case (token_index)
          7: return FID_SPEED;
          8: return FID_COURSE;
          9: return FID_DATE;
          default: return FID_NONE;
        endcase
      end
      return FID_NONE;
    endfunction

    function void take_byte(logic [7:0] b, logic eoi);
      result_t    r;
      logic [1:0] typ;
      logic [3:0] fid;
      int         limit;
      r = '0;
      if (eoi || b == CHAR_DOLLAR) begin
        if (in_sentence && sentence_bytes > 0) begin
          typ = (token_index == 0) ? name_type() : current_type;
          r.kind = 1'b1;
          r.sentence_type = typ;
          if (typ == TYPE_GGA && token_index + 1 >= gga_min) begin
            r.accepted = 1'b1;
            gga_seen = 1;
          end else if (typ == TYPE_RMC && token_index + 1 >= rmc_min) begin
            r.accepted = 1'b1;
            rmc_seen = 1;
          end
          if (gga_seen && rmc_seen) begin
            r.pair_ready = 1'b1;
            gga_seen = 0;
            rmc_seen = 0;
          end
          expected_fields.push_back(r);
        end
        in_sentence = !eoi;
        clear_sentence();
        return;
      end
      if (!in_sentence || sentence_bytes >= SENTENCE_LIMIT) return;
      sentence_bytes++;
      if (b == CHAR_COMMA && token_index < TOKEN_LIMIT - 1) begin
        if (token_index == 0) current_type = name_type();
        token_index++;
        token_chars = 0;
        return;
      end
      if (token_index == 0) begin
        if (type_length < 5) type_text = {type_text[31:0], b};
        if (type_length < 6) type_length++;
        return;
      end
      fid = token_field(limit);
      if (fid == FID_NONE || token_chars >= limit) return;
      token_chars++;
      r.field_id = fid;
      r.char_value = b;
      r.sentence_type = current_type;
      expected_fields.push_back(r);
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [15:0] data, logic kind);
      result_t got;
      result_t want;
      got = {data, kind};
      if (expected_fields.size() == 0) begin
        $error("result %h arrived with nothing expected", got);
        errors++;
        return;
      end
      want = expected_fields.pop_front();
      compare("kind", 8'(want.kind), 8'(got.kind));
      compare("field_id", 8'(want.field_id), 8'(got.field_id));
      compare("char_value", want.char_value, got.char_value);
      compare("sentence_type", 8'(want.sentence_type), 8'(got.sentence_type));
      compare("accepted", 8'(want.accepted), 8'(got.accepted));
      compare("pair_ready", 8'(want.pair_ready), 8'(got.pair_ready));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [4:0]  cfg_data;

  int idle_pct = 18;
  int sent_count = 0;
  nmea_field_scoreboard sb = new();

  nmea_gga_rmc_field_extractor i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (s_tvalid && s_tready) sb.take_byte(s_tdata, s_tlast);
    end
  end

  function automatic logic [7:0] field_char();
    logic [7:0] c;
    if ($urandom_range(0, 19) == 0) c = 8'($urandom_range(0, 255));
    else c = 8'($urandom_range(8'h30, 8'h5A));
    return c;
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(logic [4:0] gga_min, logic [4:0] rmc_min,
                               logic [4:0] field_max);
    cfg_we <= 1'b1;
    cfg_index <= REG_GGA_MIN;
    cfg_data <= gga_min;
    sb.write_reg(REG_GGA_MIN, gga_min);
    @(posedge clk);
    cfg_index <= REG_RMC_MIN;
    cfg_data <= rmc_min;
    sb.write_reg(REG_RMC_MIN, rmc_min);
    @(posedge clk);
    cfg_index <= REG_FIELD_MAX;
    cfg_data <= field_max;
    sb.write_reg(REG_FIELD_MAX, field_max);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_sentence(logic [1:0] kind);
    int tokens;
    int len;
    send_byte(CHAR_DOLLAR, 1'b0);
    case (kind)
      TYPE_GGA: send_text("GPGGA");
      TYPE_RMC: send_text("GPRMC");
      default: begin
        case ($urandom_range(0, 4))
          0: send_text("GPGSV");
          1: send_text("GPGGAX");
          2: send_text("GPGG");
          3: send_text("GPRMB");
          default: begin
            len = $urandom_range(1, 7);
            repeat (len) send_byte(field_char(), 1'b0);
          end
        endcase
      end
    endcase
    tokens = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(9, 16);
    repeat (tokens) begin
      send_byte(CHAR_COMMA, 1'b0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 2);
      repeat (len) send_byte(field_char(), 1'b0);
    end
    if ($urandom_range(0, 2) != 0) send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_noise();
    int         n;
    logic [7:0] b;
    n = $urandom_range(3, 10);
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 4) == 0) b = CHAR_COMMA;
      send_byte(b, $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic send_long_sentence();
    send_byte(CHAR_DOLLAR, 1'b0);
    send_text("GPGGA");
    for (int i = 0; i < 270; i++) begin
      if (i % 3 == 0) send_byte(CHAR_COMMA, 1'b0);
      else send_byte(field_char(), 1'b0);
    end
    send_byte(CHAR_DOLLAR, 1'b1);
  endtask

  initial begin
    int phase;
    int phase_end;
    int random_target;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_GGA_MIN;
    cfg_data <= '0;
    m_tready <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'h41, 1'b1);
    send_byte(CHAR_DOLLAR, 1'b0);
    send_byte(CHAR_DOLLAR, 1'b0);
    send_text("GPRMC,,,,,,,");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CHAR_COMMA, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(CHAR_DOLLAR, 1'b0);
    send_text("GPGGA");
    send_byte(8'h00, 1'b1);

    random_target = sent_count + RANDOM_BYTES;
    phase = 0;
    while (phase < PHASE_COUNT || sent_count < random_target) begin
      drain();
      case (phase)
        0: set_registers(5'd15, 5'd10, 5'd15);
        1: set_registers(5'd1, 5'd1, 5'd1);
        2: set_registers(5'd20, 5'd20, 5'd15);
        3: set_registers(5'd0, 5'd31, 5'd0);
        4: set_registers(5'd31, 5'd0, 5'd7);
        default: set_registers(5'($urandom_range(1, 20)), 5'($urandom_range(1, 20)),
                               5'($urandom_range(1, 15)));
      endcase
      idle_pct = (phase == 1) ? 0 : 18;
      if (phase == 1) begin
        send_long_sentence();
      end
      phase_end = sent_count + PHASE_BYTES;
      while (sent_count < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: send_sentence(TYPE_GGA);
          4, 5, 6, 7: send_sentence(TYPE_RMC);
          8: send_sentence(TYPE_OTHER);
          default: send_noise();
        endcase
        if ($urandom_range(0, 19) == 0) drain();
      end
      phase++;
    end
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    drain();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
